@@ rtl/core/mste_pkg.sv @@
// ----------------------------------------------------------------------------
// mste_pkg
// Shared constants and codes for the matrix stack transform engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mste_pkg;

  localparam int DEF_STACK_DEPTH = 8;
  localparam int DEF_FRAC_BITS   = 16;

  typedef enum logic [3:0] {
    MODE_IDENTITY        = 4'd0,
    MODE_SET_TRANSLATE   = 4'd1,
    MODE_TRANSLATE       = 4'd2,
    MODE_SCALE           = 4'd3,
    MODE_ROT_X           = 4'd4,
    MODE_ROT_Y           = 4'd5,
    MODE_ROT_Z           = 4'd6,
    MODE_TRANSFORM       = 4'd7,
    MODE_PUSH            = 4'd8,
    MODE_POP             = 4'd9,
    MODE_CLR_TRANSLATION = 4'd10,
    MODE_CLR_ROTATION    = 4'd11
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_PUSH_FULL  = 2'd1,
    STATUS_POP_EMPTY  = 2'd2,
    STATUS_SATURATED  = 2'd3
  } status_t;

endpackage

`default_nettype wire

@@ rtl/core/matrix_stack_transform_engine.sv @@
// ----------------------------------------------------------------------------
// matrix_stack_transform_engine
// 4x4 affine matrix with a push/pop stack, fixed point with saturating sums.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries mode, coord_x/y/z, cos_term and
//   sin_term. Output channel (out_valid/out_stall) returns out_x/y/z and
//   status, one result transaction per input transaction, in order.
//   An accepted transaction lands in an input register; once the result
//   register can take it, all products (12 for scale/translate/transform, 16
//   for a rotation, in parallel) and saturating sums are formed, the matrix
//   and stack are updated and the result register is loaded. Throughput is
//   one transaction per cycle while the receiver does not stall, set by the
//   single update of the matrix register each cycle.
//   Reset loads the identity matrix, empties the stack and drops anything in
//   flight. While the receiver stalls, the result holds, the input register
//   fills, and in_stall then rises until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_stack_transform_engine
  import mste_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic        [3:0]  mode,
  input  wire logic signed [31:0] coord_x,
  input  wire logic signed [31:0] coord_y,
  input  wire logic signed [31:0] coord_z,
  input  wire logic signed [17:0] cos_term,
  input  wire logic signed [17:0] sin_term,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_x,
  output logic signed [31:0]      out_y,
  output logic signed [31:0]      out_z,
  output logic        [1:0]       status
);

  localparam int LVL_W = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam logic signed [31:0] ONE_FX = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] I32_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] I32_MIN = -64'sh0000_0000_8000_0000;
  localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(STACK_DEPTH);

  function automatic logic signed [63:0] mulq(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p >>> FRAC_BITS;
  endfunction

  function automatic logic ovf(input logic signed [63:0] v);
    return (v > I32_MAX) || (v < I32_MIN);
  endfunction

  function automatic logic signed [31:0] sat(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > I32_MAX) r = 32'sh7FFF_FFFF;
    else if (v < I32_MIN) r = -32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // input register
  logic               s1_valid;
  logic [3:0]         s1_mode;
  logic signed [31:0] s1_crd [3];
  logic signed [17:0] s1_cos, s1_sin;

  // state
  logic signed [31:0] m      [4][4];
  logic signed [31:0] saved  [STACK_DEPTH][4][4];
  logic [LVL_W-1:0]   level;

  logic               advance, take_in, fire;
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign take_in  = in_valid && !in_stall;
  assign fire     = s1_valid && advance;

  // datapath
  logic signed [63:0] sp   [4][3];
  logic signed [63:0] tsum [4];
  logic signed [31:0] cs, sn;
  logic signed [31:0] ra   [4];
  logic signed [31:0] rb   [4];
  logic signed [63:0] na   [4];
  logic signed [63:0] nb   [4];
  logic [1:0]         ca, cb;
  logic               neg;

  logic signed [31:0] m_next [4][4];
  logic [LVL_W-1:0]   level_next;
  logic               push_en;
  logic               pop_en;
  logic               sat_hit;
  logic [1:0]         status_next;
  logic signed [31:0] px, py, pz;
  logic [IDX_W-1:0]   push_idx, pop_idx;

  assign push_idx = level[IDX_W-1:0];
  assign pop_idx  = IDX_W'(level - LVL_W'(1));
  assign cs = {{14{s1_cos[17]}}, s1_cos};
  assign sn = {{14{s1_sin[17]}}, s1_sin};

  always_comb begin
    // column pair and sign of the rotation
    ca  = 2'd0;
    cb  = 2'd1;
    neg = 1'b0;
    case (mode_t'(s1_mode))
      MODE_ROT_X: begin
        ca = 2'd1;
        cb = 2'd2;
      end
      MODE_ROT_Y: begin
        cb  = 2'd2;
        neg = 1'b1;
      end
      default: ;
    endcase

    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 3; c++) sp[r][c] = mulq(m[r][c], s1_crd[c]);
      tsum[r] = 64'(m[r][3]) + sp[r][0] + sp[r][1] + sp[r][2];
      ra[r] = m[r][ca];
      rb[r] = m[r][cb];
      if (neg) begin
        na[r] = mulq(ra[r], cs) - mulq(rb[r], sn);
        nb[r] = mulq(ra[r], sn) + mulq(rb[r], cs);
      end else begin
        na[r] = mulq(ra[r], cs) + mulq(rb[r], sn);
        nb[r] = mulq(rb[r], cs) - mulq(ra[r], sn);
      end
    end

    m_next      = m;
    level_next  = level;
    push_en     = 1'b0;
    pop_en      = 1'b0;
    sat_hit     = 1'b0;
    status_next = STATUS_OK;
    px = '0;
    py = '0;
    pz = '0;

    case (mode_t'(s1_mode))
      MODE_IDENTITY, MODE_SET_TRANSLATE: begin
        for (int r = 0; r < 4; r++)
          for (int c = 0; c < 4; c++) m_next[r][c] = (r == c) ? ONE_FX : '0;
        if (s1_mode == MODE_SET_TRANSLATE) begin
          for (int r = 0; r < 3; r++) m_next[r][3] = s1_crd[r];
        end
      end
      MODE_TRANSLATE: begin
        for (int r = 0; r < 4; r++) begin
          m_next[r][3] = sat(tsum[r]);
          sat_hit = sat_hit | ovf(tsum[r]);
        end
      end
      MODE_SCALE: begin
        for (int r = 0; r < 4; r++)
          for (int c = 0; c < 3; c++) begin
            m_next[r][c] = sat(sp[r][c]);
            sat_hit = sat_hit | ovf(sp[r][c]);
          end
      end
      MODE_ROT_X, MODE_ROT_Y, MODE_ROT_Z: begin
        for (int r = 0; r < 4; r++) begin
          m_next[r][ca] = sat(na[r]);
          m_next[r][cb] = sat(nb[r]);
          sat_hit = sat_hit | ovf(na[r]) | ovf(nb[r]);
        end
      end
      MODE_TRANSFORM: begin
        px = sat(tsum[0]);
        py = sat(tsum[1]);
        pz = sat(tsum[2]);
        sat_hit = ovf(tsum[0]) | ovf(tsum[1]) | ovf(tsum[2]);
      end
      MODE_PUSH: begin
        if (level < LVL_FULL) begin
          push_en    = 1'b1;
          level_next = level + LVL_W'(1);
        end else begin
          status_next = STATUS_PUSH_FULL;
        end
      end
      MODE_POP: begin
        if (level != '0) begin
          level_next = level - LVL_W'(1);
          pop_en     = 1'b1;
        end else begin
          status_next = STATUS_POP_EMPTY;
        end
      end
      MODE_CLR_TRANSLATION: begin
        for (int r = 0; r < 3; r++) m_next[r][3] = '0;
        for (int c = 0; c < 3; c++) m_next[3][c] = '0;
        m_next[3][3] = ONE_FX;
      end
      MODE_CLR_ROTATION: begin
        for (int r = 0; r < 3; r++)
          for (int c = 0; c < 3; c++) m_next[r][c] = (r == c) ? ONE_FX : '0;
      end
      default: ;
    endcase

    if (sat_hit) status_next = STATUS_SATURATED;
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      s1_mode   <= mode;
      s1_crd[0] <= coord_x;
      s1_crd[1] <= coord_y;
      s1_crd[2] <= coord_z;
      s1_cos    <= cos_term;
      s1_sin    <= sin_term;
    end
    if (fire) begin
      out_x  <= px;
      out_y  <= py;
      out_z  <= pz;
      status <= status_next;
      if (push_en) saved[push_idx] <= m;
    end
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      level     <= '0;
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++) m[r][c] <= (r == c) ? ONE_FX : '0;
    end else begin
      s1_valid <= take_in || (s1_valid && !advance);
      if (advance) out_valid <= s1_valid;
      if (fire) begin
        if (pop_en) m <= saved[pop_idx];
        else m <= m_next;
        level <= level_next;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/mste_checker.sv @@
// ----------------------------------------------------------------------------
// mste_checker
// Port-level checks for the matrix stack transform engine.
// ----------------------------------------------------------------------------
`default_nettype none

module mste_checker
  import mste_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic signed [31:0] out_x,
  input wire logic signed [31:0] out_y,
  input wire logic signed [31:0] out_z,
  input wire logic        [1:0]  status
);

  // stack errors never carry a point
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STATUS_PUSH_FULL || status == STATUS_POP_EMPTY)
      |-> out_x == '0 && out_y == '0 && out_z == '0)
    else $error("stack error transaction with nonzero point");

  // nothing in flight survives reset
  a_rst_flush: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result offered right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_y)
      && $stable(out_z) && $stable(status))
    else $error("stalled result changed");

endmodule

bind matrix_stack_transform_engine mste_checker u_mste_checker (.*);

`default_nettype wire

@@ verif/matrix_stack_transform_engine_checker.sv @@
// ----------------------------------------------------------------------------
// matrix_stack_transform_engine_checker
// Watches both channels, predicts each result from the matrix and stack
// state it tracks itself, and compares every result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module matrix_stack_transform_engine_checker
  import mste_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic        [3:0]  mode,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  input  logic signed [31:0] coord_z,
  input  logic signed [17:0] cos_term,
  input  logic signed [17:0] sin_term,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_x,
  input  logic signed [31:0] out_y,
  input  logic signed [31:0] out_z,
  input  logic        [1:0]  status,
  output int                 errors,
  output int                 pending
);

  localparam int DEPTH = DEF_STACK_DEPTH;
  localparam int FB    = DEF_FRAC_BITS;
  localparam logic signed [31:0] ONE = 32'sd1 <<< FB;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    status_t            st;
  } point_result_t;

  logic signed [31:0] mtx [16];
  logic signed [31:0] saved [DEPTH][16];
  int                 level;
  bit                 clamped;
  point_result_t      expected_points [$];

  assign pending = expected_points.size();

  function automatic logic signed [63:0] fx_mul(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p >>> FB;
  endfunction

  function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) begin
      clamped = 1;
      return 32'sh7FFF_FFFF;
    end
    if (v < -64'sh8000_0000) begin
      clamped = 1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  task automatic load_identity();
    for (int i = 0; i < 16; i++) mtx[i] = (i % 5 == 0) ? ONE : 32'sd0;
  endtask

  // rotate columns ca/cb of every row; flip selects the Y-axis sign pattern
  task automatic spin_cols(int ca, int cb, logic signed [63:0] c, logic signed [63:0] s,
                           bit flip);
    logic signed [63:0] a, b, na, nb;
    for (int r = 0; r < 4; r++) begin
      a = mtx[r*4+ca];
      b = mtx[r*4+cb];
      if (!flip) begin
        na = fx_mul(a, c) + fx_mul(b, s);
        nb = fx_mul(b, c) - fx_mul(a, s);
      end else begin
        na = fx_mul(a, c) - fx_mul(b, s);
        nb = fx_mul(a, s) + fx_mul(b, c);
      end
      mtx[r*4+ca] = clamp32(na);
      mtx[r*4+cb] = clamp32(nb);
    end
  endtask

  task automatic apply_op();
    point_result_t res;
    logic signed [63:0] x, y, z, c, s, v;
    x = coord_x; y = coord_y; z = coord_z; c = cos_term; s = sin_term;
    res = '0;
    res.st = STATUS_OK;
    clamped = 0;
    case (mode)
      MODE_IDENTITY: load_identity();
      MODE_SET_TRANSLATE: begin
        load_identity();
        mtx[3] = coord_x; mtx[7] = coord_y; mtx[11] = coord_z;
      end
      MODE_TRANSLATE: begin
        for (int r = 0; r < 4; r++) begin
          v = 64'(mtx[r*4+3]) + fx_mul(x, mtx[r*4]) + fx_mul(y, mtx[r*4+1])
              + fx_mul(z, mtx[r*4+2]);
          mtx[r*4+3] = clamp32(v);
        end
      end
      MODE_SCALE: begin
        for (int r = 0; r < 4; r++) begin
          mtx[r*4]   = clamp32(fx_mul(mtx[r*4], x));
          mtx[r*4+1] = clamp32(fx_mul(mtx[r*4+1], y));
          mtx[r*4+2] = clamp32(fx_mul(mtx[r*4+2], z));
        end
      end
      MODE_ROT_X: spin_cols(1, 2, c, s, 0);
      MODE_ROT_Y: spin_cols(0, 2, c, s, 1);
      MODE_ROT_Z: spin_cols(0, 1, c, s, 0);
      MODE_TRANSFORM: begin
        res.x = clamp32(fx_mul(x, mtx[0]) + fx_mul(y, mtx[1]) + fx_mul(z, mtx[2])
                        + 64'(mtx[3]));
        res.y = clamp32(fx_mul(x, mtx[4]) + fx_mul(y, mtx[5]) + fx_mul(z, mtx[6])
                        + 64'(mtx[7]));
        res.z = clamp32(fx_mul(x, mtx[8]) + fx_mul(y, mtx[9]) + fx_mul(z, mtx[10])
                        + 64'(mtx[11]));
      end
      MODE_PUSH: begin
        if (level < DEPTH) begin
          saved[level] = mtx;
          level++;
        end else res.st = STATUS_PUSH_FULL;
      end
      MODE_POP: begin
        if (level > 0) begin
          level--;
          mtx = saved[level];
        end else res.st = STATUS_POP_EMPTY;
      end
      MODE_CLR_TRANSLATION: begin
        mtx[3] = 0; mtx[7] = 0; mtx[11] = 0;
        mtx[12] = 0; mtx[13] = 0; mtx[14] = 0; mtx[15] = ONE;
      end
      MODE_CLR_ROTATION: begin
        for (int r = 0; r < 3; r++)
          for (int k = 0; k < 3; k++) mtx[r*4+k] = (r == k) ? ONE : 32'sd0;
      end
      default: ;
    endcase
    if (clamped) res.st = STATUS_SATURATED;
    expected_points.insert(expected_points.size(), res);
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  initial begin
    errors = 0;
    level = 0;
    load_identity();
  end

  always @(posedge clk) begin
    point_result_t w;
    if (rst) begin
      level = 0;
      load_identity();
      expected_points.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_points.size() == 0) report("unexpected result", 0, 0);
        else begin
          w = expected_points.pop_front();
          if (out_x !== w.x) report("out_x", out_x, w.x);
          if (out_y !== w.y) report("out_y", out_y, w.y);
          if (out_z !== w.z) report("out_z", out_z, w.z);
          if (status !== w.st) report("status", status, w.st);
        end
      end
      if (in_valid && !in_stall) apply_op();
    end
  end

endmodule

@@ verif/matrix_stack_transform_engine_test.sv @@
// ----------------------------------------------------------------------------
// matrix_stack_transform_engine_test
// Drives directed and random operation sequences with random gaps and
// output stalls; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module matrix_stack_transform_engine_test
  import mste_pkg::*;
;

  localparam int RANDOM_OPS = 800;
  localparam longint CYCLE_LIMIT = 400000;
  localparam int ONE = 65536;

  logic               clk = 0;
  logic               rst = 1;
  logic               in_valid = 0;
  logic               in_stall;
  logic        [3:0]  mode = '0;
  logic signed [31:0] coord_x = '0;
  logic signed [31:0] coord_y = '0;
  logic signed [31:0] coord_z = '0;
  logic signed [17:0] cos_term = '0;
  logic signed [17:0] sin_term = '0;
  logic               out_valid;
  logic               out_stall = 0;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic        [1:0]  status;
  int                 errors;
  int                 pending;
  longint             cycles = 0;
  bit                 sending = 1;

  always #5 clk = ~clk;

  matrix_stack_transform_engine dut (.*);

  matrix_stack_transform_engine_checker checker_i (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("matrix_stack_transform_engine_test: FAIL");
      $finish;
    end
  end

  function automatic int gap_len();
    if ($urandom_range(99) < 70) return 0;
    if ($urandom_range(99) < 85) return $urandom_range(3, 1);
    return $urandom_range(30, 5);
  endfunction

  // output stalls; quiet stretches with no stall at all
  always @(negedge clk) begin
    if (rst || !sending) out_stall <= 0;
    else if ((cycles / 500) % 3 == 0) out_stall <= 0;
    else if (out_stall) out_stall <= ($urandom_range(99) < 60);
    else out_stall <= ($urandom_range(99) < 20);
  end

  function automatic logic signed [31:0] any_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'sh7FFF_FFFF;
      2: return 32'sh8000_0000;
      default: return $signed($urandom_range(8 * ONE)) - 4 * ONE;
    endcase
  endfunction

  function automatic logic signed [17:0] any_trig();
    if ($urandom_range(9) == 0) return 18'($urandom);
    return $signed(18'($urandom_range(2 * ONE))) - 18'sd65536;
  endfunction

  // valid stays high into a back-to-back transaction and drops only for a gap
  task automatic send(logic [3:0] m, logic signed [31:0] x, logic signed [31:0] y,
                      logic signed [31:0] z, logic signed [17:0] c, logic signed [17:0] s);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1;
    mode <= m; coord_x <= x; coord_y <= y; coord_z <= z; cos_term <= c; sin_term <= s;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_random();
    logic [3:0] m;
    int pick;
    pick = $urandom_range(99);
    if (pick < 30) m = MODE_TRANSFORM;
    else if (pick < 97) m = 4'($urandom_range(MODE_CLR_ROTATION));
    else m = 4'($urandom_range(15, 12));
    send(m, any_coord(), any_coord(), any_coord(), any_trig(), any_trig());
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed: pop on empty, every mode, extremes, push overflow
    send(MODE_POP, 0, 0, 0, 0, 0);
    send(MODE_TRANSFORM, 32'sh7FFF_FFFF, 32'sh8000_0000, -1, 0, 0);
    send(MODE_SET_TRANSLATE, 32'sh7FFF_FFFF, 32'sh8000_0000, ONE, 0, 0);
    send(MODE_TRANSFORM, ONE, -ONE, 0, 0, 0);
    send(MODE_TRANSLATE, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0);
    send(MODE_IDENTITY, 0, 0, 0, 0, 0);
    send(MODE_SCALE, 2 * ONE, -3 * ONE, 32'sh8000_0000, 0, 0);
    send(MODE_ROT_X, 0, 0, 0, 18'sd65536, -18'sd65536);
    send(MODE_ROT_Y, 0, 0, 0, -18'sd131072, 18'sd131071);
    send(MODE_ROT_Z, 0, 0, 0, 18'sd46341, 18'sd46341);
    send(MODE_TRANSFORM, ONE, 2 * ONE, 3 * ONE, 0, 0);
    for (int i = 0; i < 9; i++) send(MODE_PUSH, 0, 0, 0, 0, 0);
    send(MODE_CLR_TRANSLATION, 0, 0, 0, 0, 0);
    send(MODE_CLR_ROTATION, 0, 0, 0, 0, 0);
    send(4'd15, -1, -1, -1, -1, -1);
    for (int i = 0; i < 9; i++) send(MODE_POP, 0, 0, 0, 0, 0);
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n == RANDOM_OPS / 2) begin
        // drain before continuing
        in_valid <= 0;
        while (pending != 0) @(negedge clk);
      end
      send_random();
    end
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    sending = 0;
    repeat (10) @(negedge clk);
    if (errors == 0 && pending == 0) $display("matrix_stack_transform_engine_test: PASS");
    else $display("matrix_stack_transform_engine_test: FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/mste_pkg.sv
rtl/core/matrix_stack_transform_engine.sv
rtl/core/mste_checker.sv
verif/matrix_stack_transform_engine_checker.sv
verif/matrix_stack_transform_engine_test.sv
